>>> rtl/pmfl_pkg.sv
`default_nettype none
package pmfl_pkg;

  localparam int unsigned DIVIDEND_W = 64;
  localparam int unsigned DIVISOR_W  = 33;

  localparam logic [2:0] REG_BODY_MASS    = 3'd0;
  localparam logic [2:0] REG_GRAVITY      = 3'd1;
  localparam logic [2:0] REG_TIME_STEP    = 3'd2;
  localparam logic [2:0] REG_MAX_FORCE    = 3'd3;
  localparam logic [2:0] REG_LIMIT_ENABLE = 3'd4;
  localparam logic [2:0] REG_EXT_FORCE_X  = 3'd5;
  localparam logic [2:0] REG_EXT_FORCE_Y  = 3'd6;
  localparam logic [2:0] REG_EXT_FORCE_Z  = 3'd7;

  localparam logic [30:0] BODY_MASS_RST = 31'd64225;
  localparam logic [30:0] GRAVITY_RST   = 31'd642908;
  localparam logic [30:0] TIME_STEP_RST = 31'd655;
  localparam logic [30:0] MAX_FORCE_RST = 31'h7FFFFFFF;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh000000007FFFFFFF) begin
      r = 32'h7FFFFFFF;
    end else if (v < -64'sh0000000080000000) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/pmfl_div.sv
`default_nettype none
module pmfl_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pmfl_pkg::div_req_t req,
  output      pmfl_pkg::div_rsp_t rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [5:0]                        cnt_r, cnt_nxt;
  logic [pmfl_pkg::DIVIDEND_W-1:0]   quo_r, quo_nxt;
  logic [pmfl_pkg::DIVISOR_W:0]      rem_r, rem_nxt;
  logic [pmfl_pkg::DIVISOR_W-1:0]    dsr_r, dsr_nxt;
  logic [pmfl_pkg::DIVISOR_W:0]      shifted;
  logic [pmfl_pkg::DIVISOR_W+1:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    shifted  = {rem_r[pmfl_pkg::DIVISOR_W-1:0], quo_r[pmfl_pkg::DIVIDEND_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dsr_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd63;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[pmfl_pkg::DIVISOR_W+1]) begin
        rem_nxt = trial[pmfl_pkg::DIVISOR_W:0];
        quo_nxt = {quo_r[pmfl_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[pmfl_pkg::DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

>>> rtl/point_mass_force_limited_step.sv
`default_nettype none
// Channel  Direction  Signals
// in       input      in_valid, in_ready, in_force_x/y/z
// out      output     out_valid, out_ready, out_pos_*, out_vel_*, out_acc_*, out_force_clamped
// cfg      input      cfg_we, cfg_index, cfg_data
//
// A transaction takes longer when the force is clamped. Its length is set by the
// bit-serial divider and the 32-step square root, all driven by one sequencer and
// one 32x32 multiplier.
// Reset is synchronous; it clears position, velocity and the external forces and loads the other registers' defaults.
// A finished result waits in the output register; the next transaction may be
// taken meanwhile, and the sequencer only stalls if its own result is ready first.
module point_mass_force_limited_step (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [31:0] in_force_x,
  input  wire logic [31:0] in_force_y,
  input  wire logic [31:0] in_force_z,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] out_pos_x,
  output      logic [31:0] out_pos_y,
  output      logic [31:0] out_pos_z,
  output      logic [31:0] out_vel_x,
  output      logic [31:0] out_vel_y,
  output      logic [31:0] out_vel_z,
  output      logic [31:0] out_acc_x,
  output      logic [31:0] out_acc_y,
  output      logic [31:0] out_acc_z,
  output      logic        out_force_clamped,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_MUL, S_SQ_ACC, S_MF_MUL, S_CMP, S_SQRT,
    S_CL_MUL, S_CL_DIV, S_CL_WAIT, S_TOT, S_TOT_WAIT,
    S_DV_MUL, S_DV_RND, S_V_MUL, S_V_RND, S_W_LO, S_W_HI, S_W_ADD, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [30:0]        mass_r, grav_r, dt_r, mf_r;
  logic               lim_r;
  logic signed [31:0] ext_r [3];

  logic [1:0]         idx_r;
  logic signed [31:0] f_r   [3];
  logic signed [31:0] acc_r [3];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic [63:0]        sum_r, prod_r, sq_x_r, sq_q_r, lo_r;
  logic [4:0]         sq_k_r;
  logic               clamped_r;
  logic [46:0]        dvm_r;
  logic               dvs_r;
  logic signed [63:0] ps_r;
  logic               out_valid_r;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [63:0]        sq_bit, sq_trial;
  logic [30:0]        mass_eff;
  logic signed [32:0] tot;
  logic [32:0]        tot_mag;
  logic signed [63:0] quo_s, a_val;
  logic [63:0]        rnd16;
  logic [79:0]        wide;
  logic signed [63:0] r2_s, dv_s;
  logic               last_idx;

  pmfl_pkg::div_req_t div_req;
  pmfl_pkg::div_rsp_t div_rsp;

  pmfl_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign last_idx = (idx_r == 2'd2);
  assign mass_eff = (mass_r == 31'd0) ? 31'd1 : mass_r;
  assign tot      = {f_r[idx_r][31], f_r[idx_r]} + {ext_r[idx_r][31], ext_r[idx_r]};
  assign tot_mag  = tot[32] ? (33'd0 - tot) : tot;
  assign sq_bit   = 64'd1 << {sq_k_r, 1'b0};
  assign sq_trial = sq_q_r + sq_bit;
  assign rnd16    = prod_r + 64'd32768;
  assign wide     = {16'd0, lo_r} + {prod_r[47:0], 32'd0} + 80'd65536;
  assign r2_s     = dvs_r ? -$signed({2'b00, wide[78:17]}) : $signed({2'b00, wide[78:17]});
  assign dv_s     = dvs_r ? -$signed({17'd0, dvm_r}) : $signed({17'd0, dvm_r});
  assign quo_s    = tot[32] ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
  assign a_val    = (idx_r == 2'd2) ? (quo_s - $signed({33'd0, grav_r})) : quo_s;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ_MUL: begin
        mul_a = pmfl_pkg::mag32(f_r[idx_r]);
        mul_b = pmfl_pkg::mag32(f_r[idx_r]);
      end
      S_MF_MUL: begin
        mul_a = {1'b0, mf_r};
        mul_b = {1'b0, mf_r};
      end
      S_CL_MUL: begin
        mul_a = pmfl_pkg::mag32(f_r[idx_r]);
        mul_b = {1'b0, mf_r};
      end
      S_DV_MUL: begin
        mul_a = pmfl_pkg::mag32(acc_r[idx_r]);
        mul_b = {1'b0, dt_r};
      end
      S_V_MUL: begin
        mul_a = pmfl_pkg::mag32(vel_r[idx_r]);
        mul_b = {1'b0, dt_r};
      end
      S_W_LO: begin
        mul_a = dvm_r[31:0];
        mul_b = {1'b0, dt_r};
      end
      S_W_HI: begin
        mul_a = {17'd0, dvm_r[46:32]};
        mul_b = {1'b0, dt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {15'd0, tot_mag, 16'd0} + {34'd0, mass_eff[30:1]};
    div_req.divisor  = {2'b00, mass_eff};
    if (state_r == S_CL_DIV) begin
      div_req.start    = 1'b1;
      div_req.dividend = prod_r;
      div_req.divisor  = sq_q_r[32:0];
    end else if (state_r == S_TOT) begin
      div_req.start = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_SQ_MUL;
      S_SQ_MUL:   state_nxt = S_SQ_ACC;
      S_SQ_ACC:   state_nxt = last_idx ? S_MF_MUL : S_SQ_MUL;
      S_MF_MUL:   state_nxt = S_CMP;
      S_CMP:      state_nxt = (lim_r && (sum_r > prod_r)) ? S_SQRT : S_TOT;
      S_SQRT:     if (sq_k_r == 5'd0) state_nxt = S_CL_MUL;
      S_CL_MUL:   state_nxt = S_CL_DIV;
      S_CL_DIV:   state_nxt = S_CL_WAIT;
      S_CL_WAIT:  if (div_rsp.done) state_nxt = last_idx ? S_TOT : S_CL_MUL;
      S_TOT:      state_nxt = S_TOT_WAIT;
      S_TOT_WAIT: if (div_rsp.done) state_nxt = last_idx ? S_DV_MUL : S_TOT;
      S_DV_MUL:   state_nxt = S_DV_RND;
      S_DV_RND:   state_nxt = S_V_MUL;
      S_V_MUL:    state_nxt = S_V_RND;
      S_V_RND:    state_nxt = S_W_LO;
      S_W_LO:     state_nxt = S_W_HI;
      S_W_HI:     state_nxt = S_W_ADD;
      S_W_ADD:    state_nxt = last_idx ? S_FIN : S_DV_MUL;
      S_FIN:      if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      clamped_r   <= 1'b0;
      mass_r      <= pmfl_pkg::BODY_MASS_RST;
      grav_r      <= pmfl_pkg::GRAVITY_RST;
      dt_r        <= pmfl_pkg::TIME_STEP_RST;
      mf_r        <= pmfl_pkg::MAX_FORCE_RST;
      lim_r       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ext_r[i] <= '0;
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          pmfl_pkg::REG_BODY_MASS:    mass_r   <= cfg_data[30:0];
          pmfl_pkg::REG_GRAVITY:      grav_r   <= cfg_data[30:0];
          pmfl_pkg::REG_TIME_STEP:    dt_r     <= cfg_data[30:0];
          pmfl_pkg::REG_MAX_FORCE:    mf_r     <= cfg_data[30:0];
          pmfl_pkg::REG_LIMIT_ENABLE: lim_r    <= cfg_data[0];
          pmfl_pkg::REG_EXT_FORCE_X:  ext_r[0] <= cfg_data;
          pmfl_pkg::REG_EXT_FORCE_Y:  ext_r[1] <= cfg_data;
          pmfl_pkg::REG_EXT_FORCE_Z:  ext_r[2] <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            f_r[0] <= in_force_x;
            f_r[1] <= in_force_y;
            f_r[2] <= in_force_z;
            idx_r  <= '0;
            sum_r  <= '0;
          end
        end
        S_SQ_MUL, S_MF_MUL, S_CL_MUL, S_DV_MUL, S_V_MUL: prod_r <= mul_p;
        S_SQ_ACC: begin
          sum_r <= sum_r + prod_r;
          idx_r <= last_idx ? 2'd0 : idx_r + 2'd1;
        end
        S_CMP: begin
          clamped_r <= lim_r && (sum_r > prod_r);
          sq_x_r    <= sum_r;
          sq_q_r    <= '0;
          sq_k_r    <= 5'd31;
        end
        S_SQRT: begin
          if (sq_x_r >= sq_trial) begin
            sq_x_r <= sq_x_r - sq_trial;
            sq_q_r <= (sq_q_r >> 1) + sq_bit;
          end else begin
            sq_q_r <= sq_q_r >> 1;
          end
          sq_k_r <= sq_k_r - 5'd1;
        end
        S_CL_WAIT: begin
          if (div_rsp.done) begin
            f_r[idx_r] <= f_r[idx_r][31] ? (32'd0 - div_rsp.quotient[31:0])
                                         : div_rsp.quotient[31:0];
            idx_r      <= last_idx ? 2'd0 : idx_r + 2'd1;
          end
        end
        S_TOT_WAIT: begin
          if (div_rsp.done) begin
            acc_r[idx_r] <= pmfl_pkg::sat32(a_val);
            idx_r        <= last_idx ? 2'd0 : idx_r + 2'd1;
          end
        end
        S_DV_RND: begin
          dvm_r <= rnd16[62:16];
          dvs_r <= acc_r[idx_r][31];
        end
        S_V_RND: begin
          ps_r <= $signed({{32{pos_r[idx_r][31]}}, pos_r[idx_r]})
                + (vel_r[idx_r][31] ? -$signed({17'd0, rnd16[62:16]})
                                    : $signed({17'd0, rnd16[62:16]}));
        end
        S_W_LO: prod_r <= mul_p;
        S_W_HI: begin
          lo_r   <= prod_r;
          prod_r <= mul_p;
        end
        S_W_ADD: begin
          pos_r[idx_r] <= pmfl_pkg::sat32(ps_r + r2_s);
          vel_r[idx_r] <= pmfl_pkg::sat32($signed({{32{vel_r[idx_r][31]}}, vel_r[idx_r]}) + dv_s);
          idx_r        <= last_idx ? 2'd0 : idx_r + 2'd1;
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r       <= 1'b1;
            out_pos_x         <= pos_r[0];
            out_pos_y         <= pos_r[1];
            out_pos_z         <= pos_r[2];
            out_vel_x         <= vel_r[0];
            out_vel_y         <= vel_r[1];
            out_vel_z         <= vel_r[2];
            out_acc_x         <= acc_r[0];
            out_acc_y         <= acc_r[1];
            out_acc_z         <= acc_r[2];
            out_force_clamped <= clamped_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A transaction was accepted while another was in progress.");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_CL_WAIT || state_r == S_TOT_WAIT))
    else $error("The divider finished while the sequencer was not waiting for it.");

  a_sqrt_only_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (clamped_r && lim_r))
    else $error("The square root ran without the force limit applying.");

  a_fin_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("A finished result was not presented at the output.");

endmodule
`default_nettype wire
